// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port checker in hdl/vpa_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- hdl/vpa_pkg.sv -----
// Types and codes of the variable partition allocator.
// Used by every module but vpa_table; depends on nothing.
package vpa_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_OWNER  = 3'd4
  } vpa_status_t;

  localparam logic [1:0] POL_BEST    = 2'd1;
  localparam logic [1:0] POL_WORST   = 2'd2;
  localparam logic       OP_RELEASE  = 1'b1;
  localparam logic       CFG_POLICY  = 1'b0;
  localparam logic       CFG_MEMSIZE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  owner_id;
    logic [10:0] request_size;
  } vpa_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] start_address;
    logic [5:0] used_segments;
  } vpa_out_t;

  typedef struct packed {
    logic       init;
    logic [1:0] policy;
  } vpa_ctl_t;

endpackage

// ----- hdl/vpa_table.sv -----
// Segment table memory: one write port, one registered read port.
// Depends on nothing.
module vpa_table #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/vpa_seq.sv -----
// Sequencer: rebuilds, scans, shifts and compacts the segment table one entry
// at a time. Depends on vpa_pkg and vpa_table.
module vpa_seq #(
  parameter int MEM_UNITS    = 1024,
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  vpa_pkg::vpa_ctl_t                ctl,
  input  logic [$clog2(MEM_UNITS+1)-1:0]   eff_size,
  input  logic                             start,
  input  vpa_pkg::vpa_in_t                 req,
  output logic                             ready,
  output logic                             res_valid,
  output vpa_pkg::vpa_out_t                res,
  input  logic                             res_ack
);

  localparam int AW = $clog2(MEM_UNITS);
  localparam int LW = $clog2(MEM_UNITS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = AW + LW + 9;
  localparam int XW = (LW > 11) ? LW : 11;

  typedef enum logic [12:0] {
    S_INIT     = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_SCAN_RD  = 13'b0000000000100,
    S_SCAN_EV  = 13'b0000000001000,
    S_DECIDE   = 13'b0000000010000,
    S_SHIFT_RD = 13'b0000000100000,
    S_SHIFT_WR = 13'b0000001000000,
    S_PUT_HOLE = 13'b0000010000000,
    S_PUT_OWN  = 13'b0000100000000,
    S_REL_RD   = 13'b0001000000000,
    S_REL_EV   = 13'b0010000000000,
    S_REL_END  = 13'b0100000000000,
    S_RESP     = 13'b1000000000000
  } state_t;

  state_t state;

  logic [CW-1:0] idx, cnt, busy_cnt, w;
  logic [IW-1:0] pick;
  logic [AW-1:0] pstart;
  logic [LW-1:0] plen, size;
  logic          found, freed;
  logic [7:0]    owner;
  logic [AW-1:0] acc_start;
  logic [LW-1:0] acc_len;
  logic [7:0]    acc_owner;
  logic          acc_busy;
  logic [2:0]    res_status;
  logic [AW-1:0] res_addr;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [AW-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic [7:0]    rd_owner;
  logic          rd_busy, fit, take, hit, e_busy, merge;
  logic [CW-1:0] idx_next;
  logic [XW-1:0] req_ext, eff_ext;
  logic [31:0]   addr_wide, busy_wide;

  vpa_table #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    rd_start = rdata[EW-1 -: AW];
    rd_len   = rdata[LW+8 -: LW];
    rd_owner = rdata[8:1];
    rd_busy  = rdata[0];
    fit      = !rd_busy && (rd_len >= size);
    take     = fit && (!found ||
               (ctl.policy == vpa_pkg::POL_BEST && rd_len < plen) ||
               (ctl.policy == vpa_pkg::POL_WORST && rd_len > plen));
    hit      = rd_busy && (rd_owner == owner);
    e_busy   = rd_busy && !hit;
    merge    = (w != '0) && !e_busy && !acc_busy;
    idx_next = idx + CW'(1);
    req_ext  = XW'(req.request_size);
    eff_ext  = XW'(eff_size);
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = idx[IW-1:0];
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = {AW'(0), eff_size, 8'd0, 1'b0};
      end
      S_SHIFT_RD: raddr = IW'(idx - CW'(1));
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = idx[IW-1:0];
        wdata = rdata;
      end
      S_PUT_HOLE: begin
        we    = 1'b1;
        waddr = IW'(pick + IW'(1));
        wdata = {AW'(pstart + AW'(size)), LW'(plen - size), 8'd0, 1'b0};
      end
      S_PUT_OWN: begin
        we    = 1'b1;
        waddr = pick;
        wdata = {pstart, size, owner, 1'b1};
      end
      S_REL_EV: begin
        we    = !merge && (w != '0);
        waddr = IW'(w - CW'(1));
        wdata = {acc_start, acc_len, acc_owner, acc_busy};
      end
      S_REL_END: begin
        we    = 1'b1;
        waddr = IW'(w - CW'(1));
        wdata = {acc_start, acc_len, acc_owner, acc_busy};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      cnt      <= CW'(1);
      busy_cnt <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          cnt      <= CW'(1);
          busy_cnt <= '0;
          state    <= S_IDLE;
        end
        S_IDLE: begin
          if (ctl.init) begin
            state <= S_INIT;
          end else if (start) begin
            owner    <= req.owner_id;
            size     <= LW'(req.request_size);
            idx      <= '0;
            w        <= '0;
            found    <= 1'b0;
            freed    <= 1'b0;
            res_addr <= '0;
            if (req.operation == vpa_pkg::OP_RELEASE) begin
              state <= S_REL_RD;
            end else if (req.request_size == '0 || req_ext > eff_ext) begin
              res_status <= vpa_pkg::ST_BAD_SIZE;
              state      <= S_RESP;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (take) begin
            found  <= 1'b1;
            pick   <= idx[IW-1:0];
            pstart <= rd_start;
            plen   <= rd_len;
          end
          idx <= idx_next;
          if ((take && !found && ctl.policy != vpa_pkg::POL_BEST &&
               ctl.policy != vpa_pkg::POL_WORST) || idx_next >= cnt) begin
            state <= S_DECIDE;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_DECIDE: begin
          idx <= cnt;
          if (!found) begin
            res_status <= vpa_pkg::ST_NO_FIT;
            state      <= S_RESP;
          end else if (plen > size) begin
            if (cnt >= CW'(MAX_SEGMENTS)) begin
              res_status <= vpa_pkg::ST_FULL;
              state      <= S_RESP;
            end else if (cnt > CW'(pick) + CW'(1)) begin
              state <= S_SHIFT_RD;
            end else begin
              state <= S_PUT_HOLE;
            end
          end else begin
            state <= S_PUT_OWN;
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          idx <= idx - CW'(1);
          if (idx - CW'(1) > CW'(pick) + CW'(1)) begin
            state <= S_SHIFT_RD;
          end else begin
            state <= S_PUT_HOLE;
          end
        end
        S_PUT_HOLE: begin
          cnt   <= cnt + CW'(1);
          state <= S_PUT_OWN;
        end
        S_PUT_OWN: begin
          busy_cnt   <= busy_cnt + CW'(1);
          res_status <= vpa_pkg::ST_OK;
          res_addr   <= pstart;
          state      <= S_RESP;
        end
        S_REL_RD: state <= S_REL_EV;
        S_REL_EV: begin
          if (hit) begin
            freed <= 1'b1;
            if (busy_cnt != '0) begin
              busy_cnt <= busy_cnt - CW'(1);
            end
          end
          if (merge) begin
            acc_len <= LW'(acc_len + rd_len);
          end else begin
            acc_start <= rd_start;
            acc_len   <= rd_len;
            acc_owner <= hit ? 8'd0 : rd_owner;
            acc_busy  <= e_busy;
            w         <= w + CW'(1);
          end
          idx <= idx_next;
          state <= (idx_next >= cnt) ? S_REL_END : S_REL_RD;
        end
        S_REL_END: begin
          cnt        <= w;
          res_status <= freed ? vpa_pkg::ST_OK : vpa_pkg::ST_NO_OWNER;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (res_ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  assign addr_wide = 32'(res_addr);
  assign busy_wide = 32'(busy_cnt);
  assign ready     = (state == S_IDLE) && !ctl.init;
  assign res_valid = (state == S_RESP);
  assign res       = '{status: res_status, start_address: addr_wide[9:0],
                       used_segments: busy_wide[5:0]};

endmodule

// ----- hdl/variable_partition_allocator_core.sv -----
// Variable partition allocator: an address-ordered segment table with
// first, best and worst fit allocation and release with hole merging.
// Input channel in_valid/in_stall/in_data carries one request per
// transaction; output channel out_valid/out_stall/out_data returns exactly
// one result per request. Configuration: cfg_we with cfg_index 0 writes the
// fit policy, index 1 writes the memory size and, if the sequencer is idle,
// rebuilds the table as one hole (input stalled meanwhile).
// An allocate reads and evaluates the table one segment at a time (first fit
// stops at the first free segment that fits); if the chosen segment is
// larger than the request, the entries behind it are shifted one at a time
// and the remaining hole is written, then the owned entry. A release walks
// the table once, segment by segment, writing merged entries back. in_stall
// is high while a request is in work.
// Reset (rst, synchronous): policy first fit, memory size 1024, one hole;
// the table is rebuilt in the S_INIT state that reset enters.
// A finished result waits in the output register while out_stall is high;
// the next request may be accepted meanwhile, and its result waits in the
// sequencer until the register is free.
// Depends on vpa_pkg, vpa_seq and vpa_table.
module variable_partition_allocator_core #(
  parameter int MEM_UNITS    = 1024,
  parameter int MAX_SEGMENTS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vpa_pkg::vpa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vpa_pkg::vpa_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [10:0]       cfg_data
);

  localparam int LW = $clog2(MEM_UNITS + 1);
  localparam int SW = (LW > 11) ? LW : 11;

  logic [1:0]        fit_policy;
  logic [10:0]       memory_size;
  logic              init_req;
  logic [SW-1:0]     msz_ext;
  logic [LW-1:0]     eff_size;
  vpa_pkg::vpa_ctl_t ctl;
  logic              ready, res_valid, res_ack;
  vpa_pkg::vpa_out_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= 2'd0;
      memory_size <= 11'd1024;
      init_req    <= 1'b0;
    end else begin
      init_req <= cfg_we && (cfg_index == vpa_pkg::CFG_MEMSIZE);
      if (cfg_we && cfg_index == vpa_pkg::CFG_POLICY) begin
        fit_policy <= cfg_data[1:0];
      end
      if (cfg_we && cfg_index == vpa_pkg::CFG_MEMSIZE) begin
        memory_size <= cfg_data;
      end
    end
  end

  always_comb begin
    msz_ext = SW'(memory_size);
    priority if (memory_size == '0) begin
      eff_size = LW'(1);
    end else if (msz_ext > SW'(MEM_UNITS)) begin
      eff_size = LW'(MEM_UNITS);
    end else begin
      eff_size = LW'(msz_ext);
    end
  end

  assign ctl      = '{init: init_req, policy: fit_policy};
  assign in_stall = !ready;
  assign res_ack  = res_valid && (!out_valid || !out_stall);

  vpa_seq #(.MEM_UNITS(MEM_UNITS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .eff_size  (eff_size),
    .start     (in_valid && ready),
    .req       (in_data),
    .ready     (ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ack   (res_ack)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data <= res;
    end
  end

endmodule

// ----- hdl/vpa_checker.sv -----
// Port checker for the allocator core, bound to the core module.
// Depends on vpa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vpa_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input vpa_pkg::vpa_out_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_IMPLY(a_status_range, clk, rst, out_valid, out_data.status <= vpa_pkg::ST_NO_OWNER)
  `ASSERT_IMPLY(a_addr_zero, clk, rst, out_valid && out_data.status != vpa_pkg::ST_OK, out_data.start_address == '0)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule

bind variable_partition_allocator_core vpa_port_checker u_vpa_checker (.*);

// ----- dv/vpa_checker.sv -----
// Checker for the variable partition allocator: watches both channels and the
// register port, predicts each result from its own segment table and compares.
// Depends on vpa_pkg.
`timescale 1ns / 100ps
module vpa_checker #(
  parameter int MEM_UNITS    = 1024,
  parameter int MAX_SEGMENTS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  vpa_pkg::vpa_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  vpa_pkg::vpa_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [10:0]       cfg_data,
  output int                fail_count,
  output int                pending
);

  logic [9:0]  tbl_start [MAX_SEGMENTS];
  logic [10:0] tbl_len [MAX_SEGMENTS];
  logic [7:0]  tbl_owner [MAX_SEGMENTS];
  logic        tbl_busy [MAX_SEGMENTS];
  int          tbl_count;
  int          owned_count;
  logic [1:0]  policy;
  logic [10:0] mem_size;
  vpa_pkg::vpa_out_t expected_results[$];

  assign pending = expected_results.size();

  function automatic int eff_size();
    if (mem_size < 1) return 1;
    if (mem_size > MEM_UNITS) return MEM_UNITS;
    return int'(mem_size);
  endfunction

  function automatic void rebuild();
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      tbl_start[i] = '0;
      tbl_len[i] = '0;
      tbl_owner[i] = '0;
      tbl_busy[i] = 1'b0;
    end
    tbl_len[0] = 11'(eff_size());
    tbl_count = 1;
    owned_count = 0;
  endfunction

  function automatic vpa_pkg::vpa_out_t grant(vpa_pkg::vpa_in_t req);
    vpa_pkg::vpa_out_t r;
    int pick;
    bit found;
    pick = 0;
    found = 0;
    r = '0;
    if (req.request_size == 0 || req.request_size > eff_size()) begin
      r.status = vpa_pkg::ST_BAD_SIZE;
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_busy[i] || tbl_len[i] < req.request_size) continue;
        if (!found) begin
          pick = i;
          found = 1;
          if (policy != vpa_pkg::POL_BEST && policy != vpa_pkg::POL_WORST) break;
        end else if (policy == vpa_pkg::POL_BEST && tbl_len[i] < tbl_len[pick]) begin
          pick = i;
        end else if (policy == vpa_pkg::POL_WORST && tbl_len[i] > tbl_len[pick]) begin
          pick = i;
        end
      end
      if (!found) begin
        r.status = vpa_pkg::ST_NO_FIT;
      end else if (tbl_len[pick] > req.request_size && tbl_count >= MAX_SEGMENTS) begin
        r.status = vpa_pkg::ST_FULL;
      end else begin
        if (tbl_len[pick] > req.request_size) begin
          for (int i = tbl_count; i > pick + 1; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_len[i] = tbl_len[i-1];
            tbl_owner[i] = tbl_owner[i-1];
            tbl_busy[i] = tbl_busy[i-1];
          end
          tbl_start[pick+1] = 10'(tbl_start[pick] + req.request_size);
          tbl_len[pick+1] = tbl_len[pick] - req.request_size;
          tbl_owner[pick+1] = '0;
          tbl_busy[pick+1] = 1'b0;
          tbl_len[pick] = req.request_size;
          tbl_count++;
        end
        tbl_busy[pick] = 1'b1;
        tbl_owner[pick] = req.owner_id;
        owned_count++;
        r.status = vpa_pkg::ST_OK;
        r.start_address = tbl_start[pick];
      end
    end
    r.used_segments = 6'(owned_count);
    return r;
  endfunction

  function automatic vpa_pkg::vpa_out_t free_owner(logic [7:0] tag);
    vpa_pkg::vpa_out_t r;
    int w;
    bit freed;
    w = 0;
    freed = 0;
    r = '0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i] && tbl_owner[i] == tag) begin
        tbl_busy[i] = 1'b0;
        tbl_owner[i] = '0;
        if (owned_count > 0) owned_count--;
        freed = 1;
      end
    end
    if (!freed) begin
      r.status = vpa_pkg::ST_NO_OWNER;
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (w > 0 && !tbl_busy[i] && !tbl_busy[w-1]) begin
          tbl_len[w-1] += tbl_len[i];
        end else begin
          tbl_start[w] = tbl_start[i];
          tbl_len[w] = tbl_len[i];
          tbl_owner[w] = tbl_owner[i];
          tbl_busy[w] = tbl_busy[i];
          w++;
        end
      end
      for (int i = w; i < MAX_SEGMENTS; i++) begin
        tbl_start[i] = '0;
        tbl_len[i] = '0;
        tbl_owner[i] = '0;
        tbl_busy[i] = 1'b0;
      end
      tbl_count = w;
      r.status = vpa_pkg::ST_OK;
    end
    r.used_segments = 6'(owned_count);
    return r;
  endfunction

  always @(posedge clk) begin
    vpa_pkg::vpa_out_t want;
    if (rst) begin
      policy = '0;
      mem_size = 11'd1024;
      rebuild();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == vpa_pkg::CFG_POLICY) begin
          policy = cfg_data[1:0];
        end else begin
          mem_size = cfg_data;
          rebuild();
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.start_address !== want.start_address ||
              out_data.used_segments !== want.used_segments) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == vpa_pkg::OP_RELEASE) begin
          expected_results.push_back(free_owner(in_data.owner_id));
        end else begin
          expected_results.push_back(grant(in_data));
        end
      end
    end
  end
endmodule

// ----- dv/testbench.sv -----
// Top of the allocator testbench: clock, reset, register phases and request
// stimulus with random idling; checking is done in vpa_checker.
// Depends on vpa_pkg, variable_partition_allocator_core and vpa_checker.
`timescale 1ns / 100ps
module testbench;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  vpa_pkg::vpa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  vpa_pkg::vpa_out_t out_data;
  logic     cfg_we = 1'b0;
  logic     cfg_index = vpa_pkg::CFG_POLICY;
  logic [10:0] cfg_data = '0;
  int       fail_count;
  int       pending;
  bit       quiet = 0;
  bit       hold_off = 0;
  bit       done = 0;

  variable_partition_allocator_core dut (.*);
  vpa_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_off) begin
      out_stall <= 1'b1;
      repeat (400) @(negedge clk);
      hold_off = 0;
      out_stall <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic op, input logic [7:0] tag, input logic [10:0] units);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_data <= '{operation: op, owner_id: tag, request_size: units};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] val);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_run(input int n, input int units_max);
    int tag_max;
    tag_max = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send(1'b0, 8'($urandom), 11'($urandom));
        1: send(1'b1, 8'($urandom), 11'($urandom));
        2, 3, 4: send(1'b1, 8'($urandom_range(0, tag_max)), 11'($urandom));
        default: send(1'b0, 8'($urandom_range(0, tag_max)),
                      11'($urandom_range(1, units_max)));
      endcase
    end
  endtask

  initial begin
    logic [1:0] pols [4] = '{2'd0, vpa_pkg::POL_BEST, vpa_pkg::POL_WORST, 2'd3};
    logic [10:0] sizes [5] = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd100};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);
    // directed
    send(1'b0, 8'd1, 11'd0);
    send(1'b0, 8'd1, 11'd1025);
    send(1'b0, 8'd1, 11'd2047);
    send(1'b1, 8'd9, 11'd0);
    send(1'b0, 8'd0, 11'd1);
    send(1'b0, 8'd255, 11'd100);
    send(1'b0, 8'd255, 11'd50);
    send(1'b0, 8'd3, 11'd873);
    send(1'b0, 8'd4, 11'd1);
    send(1'b1, 8'd255, 11'd2047);
    send(1'b0, 8'd5, 11'd150);
    send(1'b1, 8'd0, 11'd0);
    send(1'b1, 8'd3, 11'd0);
    send(1'b1, 8'd5, 11'd0);
    for (int i = 0; i < 33; i++) send(1'b0, 8'(i % 4), 11'd1);
    send(1'b1, 8'd1, 11'd0);
    hold_off = 1;
    for (int i = 0; i < 33; i++) send(1'b0, 8'd7, 11'd1);
    send(1'b0, 8'd7, 11'd2);
    for (int p = 0; p < 4; p++) begin
      write_reg(vpa_pkg::CFG_POLICY, 11'(pols[p]) | 11'h7FC);
      for (int s = 0; s < 5; s++) begin
        write_reg(vpa_pkg::CFG_MEMSIZE, sizes[s]);
        if (p == 3 && s == 4) quiet = 1;
        random_run(48, (sizes[s] > 200 || sizes[s] == 0) ? 64 : 8);
      end
    end
    quiet = 1;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
